/* rtl/grpl_pkg.sv */
// ----------------------------------------------------------------------------
// grpl_pkg
// shared constants, types and table builders of the gas ratio converter
// ----------------------------------------------------------------------------
package grpl_pkg;

	localparam int FRAC_BITS      = 16;
	localparam int LOG_TABLE_BITS = 8;
	localparam int LOG_FRAC       = 24;
	localparam int EXP_FRAC       = 12;
	localparam int RAW_W          = 16;
	localparam int QW             = RAW_W + FRAC_BITS;   // quotient width
	localparam int DIV_STEP       = 4;                   // quotient bits per stage
	localparam int DIV_STAGES     = QW / DIV_STEP;
	localparam int TAB_N          = 1 << LOG_TABLE_BITS;
	localparam int LW             = LOG_FRAC + 7;        // signed log width
	localparam int EXP_W          = 13;
	localparam int QMAG_W         = LW + EXP_W - EXP_FRAC;
	localparam int V_W            = 31;                  // exp2 entry, Q.30
	localparam int SCALE_W        = 16;
	localparam int Z_W            = V_W + SCALE_W;
	localparam int NW             = 10;                  // signed exponent / shift
	localparam int OUT_W          = 24;

	localparam logic [1:0] GAS_NH3     = 2'd0;
	localparam logic [1:0] GAS_CO      = 2'd1;
	localparam logic [1:0] GAS_NO2     = 2'd2;
	localparam logic [1:0] GAS_UNKNOWN = 2'd3;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_READ = 2'd1;
	localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

	localparam logic [1:0] REG_ZERO_NH3 = 2'd0;
	localparam logic [1:0] REG_ZERO_CO  = 2'd1;
	localparam logic [1:0] REG_ZERO_NO2 = 2'd2;

	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	// clamp limits, round half up
	localparam logic [QW-1:0] LO_NH3 = QW'(((64'd4 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [QW-1:0] HI_NH3 = QW'(((64'd11 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [QW-1:0] LO_CO  = QW'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [QW-1:0] HI_CO  = QW'(64'd3 << FRAC_BITS);
	localparam logic [QW-1:0] LO_NO2 = QW'(((64'd7 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [QW-1:0] HI_NO2 = QW'(64'd70 << FRAC_BITS);

	typedef struct packed {
		logic [1:0] gas;
		logic [1:0] status;
	} tag_t;

	typedef logic [LOG_FRAC-1:0] log_tab_t [TAB_N];
	typedef logic [V_W-1:0]      exp_tab_t [TAB_N];

	function automatic logic [63:0] isqrt64(input logic [63:0] xin);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] b;
		x   = xin;
		res = 64'd0;
		b   = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 64'd0) begin
			if (x >= res + b) begin
				x   = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// log2(1 + k/2^LOG_TABLE_BITS) by repeated squaring of the mantissa
	function automatic log_tab_t build_log_tab();
		log_tab_t t;
		logic [63:0] y;
		logic [LOG_FRAC-1:0] fr;
		for (int k = 0; k < TAB_N; k++) begin
			y  = (64'd1 << 31) + (64'(k) << (31 - LOG_TABLE_BITS));
			fr = '0;
			for (int i = 0; i < LOG_FRAC; i++) begin
				y  = (y * y) >> 31;
				fr = {fr[LOG_FRAC-2:0], 1'b0};
				if (y >= (64'd1 << 32)) begin
					y     = y >> 1;
					fr[0] = 1'b1;
				end
			end
			t[k] = fr;
		end
		return t;
	endfunction

	// 2^(j/2^LOG_TABLE_BITS) as a product of successive square roots of two
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		logic [63:0] c;
		logic [63:0] v;
		for (int j = 0; j < TAB_N; j++) begin
			c = 64'd2 << 30;
			v = 64'd1 << 30;
			for (int i = 1; i <= LOG_TABLE_BITS; i++) begin
				c = isqrt64(c << 30);
				if (((j >> (LOG_TABLE_BITS - i)) & 1) != 0) v = (v * c) >> 30;
			end
			t[j] = v[V_W-1:0];
		end
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();
	localparam exp_tab_t EXP_TAB = build_exp_tab();

	function automatic logic [QW-1:0] gas_lo(input logic [1:0] gas);
		case (gas)
			GAS_CO:  return LO_CO;
			GAS_NO2: return LO_NO2;
			default: return LO_NH3;
		endcase
	endfunction

	function automatic logic [QW-1:0] gas_hi(input logic [1:0] gas);
		case (gas)
			GAS_CO:  return HI_CO;
			GAS_NO2: return HI_NO2;
			default: return HI_NH3;
		endcase
	endfunction

	// exponent magnitude, Q.12
	function automatic logic [EXP_W-1:0] gas_exp(input logic [1:0] gas);
		case (gas)
			GAS_CO:  return EXP_W'(4829);
			GAS_NO2: return EXP_W'(4125);
			default: return EXP_W'(6840);
		endcase
	endfunction

	function automatic logic gas_exp_neg(input logic [1:0] gas);
		case (gas)
			GAS_NO2: return 1'b0;
			default: return 1'b1;
		endcase
	endfunction

	// scale, Q.16
	function automatic logic [SCALE_W-1:0] gas_scale(input logic [1:0] gas);
		case (gas)
			GAS_CO:  return SCALE_W'(13107);
			GAS_NO2: return SCALE_W'(3277);
			default: return SCALE_W'(44582);
		endcase
	endfunction

endpackage

/* rtl/grpl_div.sv */
// ----------------------------------------------------------------------------
// grpl_div
// pipelined restoring divider, a few quotient bits per stage
// ----------------------------------------------------------------------------
module grpl_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [grpl_pkg::QW-1:0]   dividend,
	input  logic [15:0]               divisor,
	input  grpl_pkg::tag_t            in_tag,
	output logic                      out_valid,
	output logic [grpl_pkg::QW-1:0]   quotient,
	output grpl_pkg::tag_t            out_tag
);

	localparam int NS = grpl_pkg::DIV_STAGES;
	localparam int W  = grpl_pkg::QW;

	logic                vld_q [NS];
	logic [15:0]         rem_q [NS];
	logic [W-1:0]        wrk_q [NS];
	logic [15:0]         dvs_q [NS];
	grpl_pkg::tag_t      tag_q [NS];

	logic [15:0]         rem_d [NS];
	logic [W-1:0]        wrk_d [NS];

	always_comb begin
		for (int s = 0; s < NS; s++) begin
			logic [16:0]  r;
			logic [W-1:0] w;
			logic [15:0]  d;
			r = (s == 0) ? 17'd0 : {1'b0, rem_q[(s == 0) ? 0 : s - 1]};
			w = (s == 0) ? dividend : wrk_q[(s == 0) ? 0 : s - 1];
			d = (s == 0) ? divisor : dvs_q[(s == 0) ? 0 : s - 1];
			for (int i = 0; i < grpl_pkg::DIV_STEP; i++) begin
				r = {r[15:0], w[W-1]};
				w = {w[W-2:0], 1'b0};
				if (r >= {1'b0, d}) begin
					r    = r - {1'b0, d};
					w[0] = 1'b1;
				end
			end
			rem_d[s] = r[15:0];
			wrk_d[s] = w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NS; s++) vld_q[s] <= 1'b0;
		end else if (en) begin
			for (int s = 0; s < NS; s++) vld_q[s] <= (s == 0) ? in_valid : vld_q[(s == 0) ? 0 : s - 1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < NS; s++) begin
				rem_q[s] <= rem_d[s];
				wrk_q[s] <= wrk_d[s];
				dvs_q[s] <= (s == 0) ? divisor : dvs_q[(s == 0) ? 0 : s - 1];
				tag_q[s] <= (s == 0) ? in_tag : tag_q[(s == 0) ? 0 : s - 1];
			end
		end
	end

	assign out_valid = vld_q[NS-1];
	assign quotient  = wrk_q[NS-1];
	assign out_tag   = tag_q[NS-1];

endmodule

/* rtl/gas_ratio_power_law_converter_core.sv */
// ----------------------------------------------------------------------------
// gas_ratio_power_law_converter_core
// reading / zero resistance ratio, clamp and power law to a Q8.16 concentration
// ----------------------------------------------------------------------------
// pipeline: 8 divider stages, clamp, log2 lookup, exponent multiply, exp2 lookup,
//   scale multiply, shift/saturate
// throughput: one item per cycle; the whole pipeline holds while a result waits
// reset: arst_n clears all valid bits and sets the zero resistances to 1
module gas_ratio_power_law_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // raw_reading[15:0]
	input  logic [2:0]  s_tuser,   // req_type[1:0], reading_ok[2]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // concentration[23:0]
	output logic [1:0]  m_tuser,   // status[1:0]
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int QW     = grpl_pkg::QW;
	localparam int LW     = grpl_pkg::LW;
	localparam int LF     = grpl_pkg::LOG_FRAC;
	localparam int LTB    = grpl_pkg::LOG_TABLE_BITS;
	localparam int QMAG_W = grpl_pkg::QMAG_W;
	localparam int NW     = grpl_pkg::NW;
	localparam int Z_W    = grpl_pkg::Z_W;
	localparam int OUT_W  = grpl_pkg::OUT_W;
	localparam int SH0    = 46 - grpl_pkg::FRAC_BITS;

	// zero resistance registers
	logic [15:0] zr_nh3_q, zr_co_q, zr_no2_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zr_nh3_q <= 16'd1;
			zr_co_q  <= 16'd1;
			zr_no2_q <= 16'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				grpl_pkg::REG_ZERO_NH3: zr_nh3_q <= cfg_data;
				grpl_pkg::REG_ZERO_CO:  zr_co_q  <= cfg_data;
				grpl_pkg::REG_ZERO_NO2: zr_no2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the pipeline advances as one unless the output register is blocked
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// input decode: status and divisor select
	logic [1:0]       in_gas;
	logic             in_ok;
	logic [15:0]      in_div;
	grpl_pkg::tag_t   in_tag;

	assign in_gas = s_tuser[1:0];
	assign in_ok  = s_tuser[2];

	always_comb begin
		case (in_gas)
			grpl_pkg::GAS_CO:  in_div = zr_co_q;
			grpl_pkg::GAS_NO2: in_div = zr_no2_q;
			default:           in_div = zr_nh3_q;
		endcase
		in_tag.gas = in_gas;
		if (!in_ok) begin
			in_tag.status = grpl_pkg::STATUS_NO_READ;
		end else if (in_gas == grpl_pkg::GAS_UNKNOWN) begin
			in_tag.status = grpl_pkg::STATUS_UNKNOWN;
		end else begin
			in_tag.status = grpl_pkg::STATUS_OK;
		end
	end

	// ratio = raw << FRAC_BITS / zero resistance; a zero divisor gives all ones
	logic             dv_valid;
	logic [QW-1:0]    dv_quot;
	grpl_pkg::tag_t   dv_tag;

	grpl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.dividend  ({s_tdata, {grpl_pkg::FRAC_BITS{1'b0}}}),
		.divisor   (in_div),
		.in_tag    (in_tag),
		.out_valid (dv_valid),
		.quotient  (dv_quot),
		.out_tag   (dv_tag)
	);

	// stage 1: clamp to the gas's limits
	logic             vld_s1;
	logic [QW-1:0]    ratio_s1;
	grpl_pkg::tag_t   tag_s1;
	logic [QW-1:0]    ratio_c;

	always_comb begin
		ratio_c = dv_quot;
		if (ratio_c < grpl_pkg::gas_lo(dv_tag.gas)) ratio_c = grpl_pkg::gas_lo(dv_tag.gas);
		if (ratio_c > grpl_pkg::gas_hi(dv_tag.gas)) ratio_c = grpl_pkg::gas_hi(dv_tag.gas);
	end

	// stage 2: log2 from the msb position and a table on the bits below it
	logic             vld_s2;
	logic             lneg_s2;
	logic [LW-1:0]    lmag_s2;
	grpl_pkg::tag_t   tag_s2;
	logic [5:0]       msb_c;
	logic [QW-1:0]    norm_c;
	logic [LTB-1:0]   k_c;
	logic [6:0]       pexp_c;
	logic [LW-1:0]    l_c;

	always_comb begin
		msb_c = '0;
		for (int b = 0; b < QW; b++) begin
			if (ratio_s1[b]) msb_c = 6'(b);
		end
		norm_c = ratio_s1 << (6'(QW - 1) - msb_c);
		k_c    = norm_c[QW-2 -: LTB];
		pexp_c = 7'(msb_c) - 7'(grpl_pkg::FRAC_BITS);
		l_c    = {pexp_c, {LF{1'b0}}} + {7'd0, grpl_pkg::LOG_TAB[k_c]};
	end

	// stage 3: times the exponent magnitude, truncated
	logic             vld_s3;
	logic             pneg_s3;
	logic [QMAG_W-1:0] qmag_s3;
	grpl_pkg::tag_t   tag_s3;
	logic [LW+grpl_pkg::EXP_W-1:0] prod_c;
	logic [QMAG_W-1:0] qmag_c;

	always_comb begin
		prod_c = (LW + grpl_pkg::EXP_W)'(lmag_s2) *
		         (LW + grpl_pkg::EXP_W)'(grpl_pkg::gas_exp(tag_s2.gas));
		qmag_c = prod_c[LW+grpl_pkg::EXP_W-1:grpl_pkg::EXP_FRAC];
	end

	// stage 4: split into integer and fraction, exp2 table
	logic             vld_s4;
	logic signed [NW-1:0] n_s4;
	logic [grpl_pkg::V_W-1:0] v_s4;
	grpl_pkg::tag_t   tag_s4;
	logic [LF-1:0]    fl_c, f_c;
	logic [NW-1:0]    nhi_c;
	logic signed [NW-1:0] n_c;

	always_comb begin
		fl_c  = qmag_s3[LF-1:0];
		nhi_c = NW'(qmag_s3[QMAG_W-1:LF]);
		if (!pneg_s3) begin
			f_c = fl_c;
			n_c = $signed(nhi_c);
		end else begin
			f_c = -fl_c;
			n_c = -$signed(nhi_c + NW'(fl_c != '0));
		end
	end

	// stage 5: scale multiply
	logic             vld_s5;
	logic signed [NW-1:0] n_s5;
	logic [Z_W-1:0]   z_s5;
	grpl_pkg::tag_t   tag_s5;

	// stage 6 (output register): shift by the integer part and saturate
	logic signed [NW-1:0] sh_c;
	logic [NW-1:0]    nsh_c;
	logic [Z_W-1:0]   rsh_c;
	logic [Z_W+OUT_W-1:0] lsh_c;
	logic [OUT_W-1:0] res_c;

	always_comb begin
		sh_c  = NW'(SH0) - n_s5;
		nsh_c = -sh_c;
		rsh_c = z_s5 >> sh_c[NW-2:0];
		lsh_c = (Z_W + OUT_W)'(z_s5) << nsh_c[4:0];
		if (sh_c >= $signed(NW'(Z_W))) begin
			res_c = '0;
		end else if (!sh_c[NW-1]) begin
			res_c = (rsh_c > Z_W'(grpl_pkg::OUT_MAX)) ? grpl_pkg::OUT_MAX : rsh_c[OUT_W-1:0];
		end else if (nsh_c >= NW'(OUT_W)) begin
			res_c = grpl_pkg::OUT_MAX;
		end else begin
			res_c = (lsh_c > (Z_W + OUT_W)'(grpl_pkg::OUT_MAX)) ?
			        grpl_pkg::OUT_MAX : lsh_c[OUT_W-1:0];
		end
		// failed read or unknown gas gives zero
		if (tag_s5.status != grpl_pkg::STATUS_OK) res_c = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_s5   <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_s1   <= dv_valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_s5   <= vld_s4;
			m_tvalid <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ratio_s1 <= ratio_c;
			tag_s1   <= dv_tag;

			lneg_s2  <= l_c[LW-1];
			lmag_s2  <= l_c[LW-1] ? -l_c : l_c;
			tag_s2   <= tag_s1;

			pneg_s3  <= (lneg_s2 != grpl_pkg::gas_exp_neg(tag_s2.gas)) && (qmag_c != '0);
			qmag_s3  <= qmag_c;
			tag_s3   <= tag_s2;

			n_s4     <= n_c;
			v_s4     <= grpl_pkg::EXP_TAB[f_c[LF-1 -: LTB]];
			tag_s4   <= tag_s3;

			n_s5     <= n_s4;
			z_s5     <= Z_W'(v_s4) * Z_W'(grpl_pkg::gas_scale(tag_s4.gas));
			tag_s5   <= tag_s4;

			m_tdata  <= res_c;
			m_tuser  <= tag_s5.status;
		end
	end

	// a non-ok status always carries a zero concentration
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != grpl_pkg::STATUS_OK) |-> m_tdata == '0)
		else $error("error status with nonzero concentration");

	// status code is never the reserved value
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 2'd3)
		else $error("reserved status code");

	// a blocked result holds the whole pipeline, including the input side
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while result blocked");

	// a stalled cycle leaves the valid bit of stage 5 untouched
	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(vld_s5))
		else $error("pipeline moved during stall");

endmodule

/* verif/grpl_checker.sv */
// ----------------------------------------------------------------------------
// grpl_checker
// watches the item channels of the gas ratio converter, predicts every
// concentration and compares it with the result items in order
// ----------------------------------------------------------------------------
module grpl_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [23:0] conc;
		logic [1:0]  status;
	} conc_t;

	conc_t       conc_queue[$];
	logic [15:0] zero_res[3];

	function automatic logic [63:0] sqrt_floor(input logic [63:0] xin);
		logic [63:0] x, r, b;
		x = xin;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// log2 of a Q.16 ratio in signed Q.24
	function automatic longint ratio_log2(input logic [63:0] r);
		int          p;
		logic [63:0] m, k, y, fr;
		p = 63;
		fr = 0;
		while (p > 0 && r[p] == 1'b0) p--;
		m = (p >= 31) ? (r >> (p - 31)) : (r << (31 - p));
		k = (m >> 23) & 64'hFF;
		y = (64'd1 << 31) + (k << 23);
		for (int i = 0; i < 24; i++) begin
			y = (y * y) >> 31;
			fr = fr << 1;
			if (y >= (64'd1 << 32)) begin
				y = y >> 1;
				fr[0] = 1'b1;
			end
		end
		return longint'(p - 16) * (longint'(1) << 24) + longint'(fr);
	endfunction

	function automatic logic [63:0] frac_exp2(input logic [63:0] j);
		logic [63:0] c, v;
		c = 64'd2 << 30;
		v = 64'd1 << 30;
		for (int i = 1; i <= 8; i++) begin
			c = sqrt_floor(c << 30);
			if (j[8-i]) v = (v * c) >> 30;
		end
		return v;
	endfunction

	function automatic conc_t predict_conc(input logic [1:0] gas, input logic [15:0] raw,
			input logic ok);
		conc_t       o;
		logic [63:0] lo, hi, ex, sc, r0, ratio, lmag, qmag, f, v, z, res;
		logic        eneg, lneg, pneg;
		longint      l, pw, n, sh;
		o = '0;
		if (!ok) begin
			o.status = grpl_pkg::STATUS_NO_READ;
			return o;
		end
		if (gas == grpl_pkg::GAS_UNKNOWN) begin
			o.status = grpl_pkg::STATUS_UNKNOWN;
			return o;
		end
		case (gas)
			grpl_pkg::GAS_NH3: begin lo = 2621; hi = 72090; ex = 6840; eneg = 1; sc = 44582; end
			grpl_pkg::GAS_CO:  begin lo = 655; hi = 196608; ex = 4829; eneg = 1; sc = 13107; end
			default: begin lo = 4588; hi = 4587520; ex = 4125; eneg = 0; sc = 3277; end
		endcase
		r0 = zero_res[gas];
		ratio = (r0 == 0) ? ~64'd0 : ((64'(raw) << 16) / r0);
		if (ratio < lo) ratio = lo;
		if (ratio > hi) ratio = hi;
		l = ratio_log2(ratio);
		lneg = l < 0;
		lmag = lneg ? 64'(-l) : 64'(l);
		qmag = (lmag * ex) >> 12;
		pneg = (lneg != eneg) && qmag != 0;
		pw = pneg ? -longint'(qmag) : longint'(qmag);
		if (!pneg) n = longint'(qmag >> 24);
		else n = -longint'((qmag + 64'hFFFFFF) >> 24);
		f = 64'(pw - n * (longint'(1) << 24));
		v = frac_exp2(f >> 16);
		z = v * sc;
		sh = 30 - n;
		if (sh >= 64) res = 0;
		else if (sh >= 0) res = z >> sh;
		else if (-sh >= 40 || z > (64'hFFFFFF >> (-sh))) res = 64'hFFFFFF;
		else res = z << (-sh);
		if (res > 64'hFFFFFF) res = 64'hFFFFFF;
		o.conc = res[23:0];
		o.status = grpl_pkg::STATUS_OK;
		return o;
	endfunction

	assign pending = conc_queue.size();

	always @(posedge clk or negedge arst_n) begin
		conc_t got, want;
		int    errs;
		if (!arst_n) begin
			zero_res[0] <= 16'd1;
			zero_res[1] <= 16'd1;
			zero_res[2] <= 16'd1;
			fail_count <= 0;
			conc_queue.delete();
		end else begin
			errs = 0;
			// writes only happen while idle, so order against items is moot
			if (cfg_valid && cfg_ready && cfg_index <= grpl_pkg::REG_ZERO_NO2)
				zero_res[cfg_index] <= cfg_data;
			if (s_tvalid && s_tready)
				conc_queue.push_back(predict_conc(s_tuser[1:0], s_tdata, s_tuser[2]));
			if (m_tvalid && m_tready) begin
				got.conc = m_tdata;
				got.status = m_tuser;
				if (conc_queue.size() == 0) begin
					$error("result item with nothing expected: conc %h status %0d",
						m_tdata, m_tuser);
					errs++;
				end else begin
					want = conc_queue.pop_front();
					if (want.conc !== got.conc) begin
						$error("concentration expected %h actual %h", want.conc, got.conc);
						errs++;
					end
					if (want.status !== got.status) begin
						$error("status expected %0d actual %0d", want.status, got.status);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end
endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// drives readings and zero resistance writes into the gas ratio converter
// under random gaps and back pressure; the checker judges every result item
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	int          item_count = 0;
	int          cfg_count = 0;
	bit          no_stall = 1'b0;

	always #5 clk = ~clk;

	gas_ratio_power_law_converter_core uut (.*);

	grpl_checker chk (.*);

	// receiver back pressure, about a third of cycles, none in quiet stretches
	always @(posedge clk)
		m_tready <= no_stall ? 1'b1 : ($urandom_range(99) >= 33);

	// watchdog on cycles with no accepted item of any kind
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog: no progress");
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// valid stays high across back to back items, drops only in gaps
	task automatic send_item(input logic [1:0] gas, input logic [15:0] raw, input logic ok);
		while (!no_stall && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= raw;
		s_tuser <= {ok, gas};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		item_count++;
	endtask

	// valid stays high across a group of writes; the caller drops it
	task automatic write_zero(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_count++;
	endtask

	// wait for every expected result plus the pipeline depth
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_zero();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			default: return 16'($urandom_range(65535, 1));
		endcase
	endfunction

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(3))
			0: return 16'($urandom_range(65535));
			1: return 16'($urandom_range(255));
			2: return 16'hFFFF - 16'($urandom_range(15));
			default: return 16'($urandom_range(4095));
		endcase
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset zero resistances, then extremes and special cases
		send_item(grpl_pkg::GAS_NH3, 16'd0, 1'b1);
		send_item(grpl_pkg::GAS_CO, 16'hFFFF, 1'b1);
		send_item(grpl_pkg::GAS_NO2, 16'd1, 1'b1);
		send_item(grpl_pkg::GAS_UNKNOWN, 16'h1234, 1'b1);
		send_item(grpl_pkg::GAS_NH3, 16'hFFFF, 1'b0);
		send_item(grpl_pkg::GAS_UNKNOWN, 16'd0, 1'b0);
		drain();
		// zero register clamps to upper limit
		write_zero(grpl_pkg::REG_ZERO_NH3, 16'd0);
		write_zero(grpl_pkg::REG_ZERO_CO, 16'd0);
		write_zero(grpl_pkg::REG_ZERO_NO2, 16'd0);
		cfg_valid <= 1'b0;
		for (int g = 0; g < 3; g++) send_item(2'(g), 16'd77, 1'b1);
		drain();
		write_zero(grpl_pkg::REG_ZERO_NH3, 16'hFFFF);
		write_zero(grpl_pkg::REG_ZERO_CO, 16'hFFFF);
		write_zero(grpl_pkg::REG_ZERO_NO2, 16'hFFFF);
		cfg_valid <= 1'b0;
		for (int g = 0; g < 3; g++) begin
			send_item(2'(g), 16'd0, 1'b1);
			send_item(2'(g), 16'hFFFF, 1'b1);
			send_item(2'(g), 16'h8000, 1'b1);
		end
		drain();
		write_zero(grpl_pkg::REG_ZERO_NH3, 16'd1000);
		write_zero(grpl_pkg::REG_ZERO_CO, 16'd1000);
		write_zero(grpl_pkg::REG_ZERO_NO2, 16'd1000);
		cfg_valid <= 1'b0;
		for (int g = 0; g < 3; g++) send_item(2'(g), 16'd1000, 1'b1);

		// random phases, each with new zero resistances
		for (int ph = 0; ph < 14; ph++) begin
			drain();
			for (int r = 0; r < 3; r++) write_zero(2'(r), pick_zero());
			cfg_valid <= 1'b0;
			no_stall = (ph == 5);
			for (int i = 0; i < 100; i++) begin
				send_item(2'($urandom_range(3)), pick_raw(), $urandom_range(9) != 0);
				// sender waits until all results are back
				if (ph == 3 && i == 50) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
		end
		no_stall = 1'b0;
		drain();

		$display("covered %0d readings over all gases and %0d zero resistance writes",
			item_count, cfg_count);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
